>>> hw/rtl/facl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// facl_pkg
// shared constants and types for the fifo associative cache lookup unit
// ----------------------------------------------------------------------------
package facl_pkg;

  // fixed port widths
  localparam int IN_TAG_W = 32;
  localparam int EXT_TAG_W = 64;
  localparam int LAT_W = 10;
  localparam int HIT_LAT_W = 8;
  localparam int CAP_W = 6;
  localparam int CNT_W = 32;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_LATENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LATENCY = 2'd2;

  // register reset values
  localparam logic [CAP_W-1:0] CAPACITY_RST = 6'd32;
  localparam logic [HIT_LAT_W-1:0] HIT_LATENCY_RST = 8'd4;
  localparam logic [LAT_W-1:0] MISS_LATENCY_RST = 10'd200;

  // controls broadcast to every cell
  typedef struct packed {
    logic compare;
    logic shift;
  } facl_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/fifo_assoc_cache_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_assoc_cache_lookup_unit
// fully associative tag store with fifo replacement, one lookup per word
// ----------------------------------------------------------------------------
// usage
// - input channel: in_valid / in_stall carry block_tag; a word is taken at
//   an edge where in_valid is high and in_stall is low
// - output channel: out_valid / out_stall carry hit, latency, evict_valid,
//   evicted_tag, hit_total and memory_total, one result word per request
// - config port: cfg_write with cfg_index / cfg_data writes capacity,
//   hit_latency or miss_latency; write only while no request is in flight
// - steps: a taken request goes through a compare step, in parallel in
//   every cell, and then a resolve step that writes the result register
// - overlap: the next request is taken in the same cycle the previous one
//   resolves, so the compare of one request and the store update of the
//   previous never overlap
// - the store is a row of cells that shifts by one on every miss; the newest
//   tag sits in cell 0 and the oldest at the end of the occupied run
// - a stalled result holds its register; the resolve step waits for it, so
//   at most one request is taken while a result is still pending
// - reset clears occupancy, both counters, the handshake state and the
//   registers back to capacity 32, hit latency 4 and miss latency 200
// ----------------------------------------------------------------------------
module fifo_assoc_cache_lookup_unit
  import facl_pkg::*;
#(
  parameter int ENTRIES = 32,
  parameter int TAG_BITS = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  // config port
  input  wire                   cfg_write,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire [IN_TAG_W-1:0]    block_tag,
  // result channel
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  hit,
  output logic [LAT_W-1:0]      latency,
  output logic                  evict_valid,
  output logic [IN_TAG_W-1:0]   evicted_tag,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      memory_total
);

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP = 2'd1;
  localparam logic [1:0] ST_RES = 2'd2;

  // config registers
  logic [CAP_W-1:0]     capacity;
  logic [HIT_LAT_W-1:0] hit_latency;
  logic [LAT_W-1:0]     miss_latency;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [TAG_BITS-1:0]  req_tag;
  logic [OCC_W-1:0]     occupancy;
  logic [CNT_W-1:0]     hit_counter;
  logic [CNT_W-1:0]     memory_counter;

  logic                 in_accept;
  logic                 res_go;
  logic                 any_hit;
  logic                 full;
  logic [CW-1:0]        cap_eff;
  logic [TAG_BITS-1:0]  evict_tag;
  logic [EXT_TAG_W-1:0] tag_in_ext;
  logic [EXT_TAG_W-1:0] evict_ext;
  facl_ctl_t            ctl;

  logic [TAG_BITS-1:0]  cell_tag [ENTRIES];
  logic [TAG_BITS-1:0]  cell_last [ENTRIES];
  logic [ENTRIES-1:0]   cell_match;

  assign in_accept = in_valid && !in_stall;
  // resolve only when the result register is free or being drained
  assign res_go = (state == ST_RES) && !(out_valid && out_stall);
  assign in_stall = !((state == ST_IDLE) || res_go);

  assign ctl.compare = (state == ST_CMP);
  assign ctl.shift = res_go && !any_hit;

  // only the low TAG_BITS bits of the request take part
  assign tag_in_ext = EXT_TAG_W'(block_tag);
  assign evict_ext = EXT_TAG_W'(evict_tag);

  // ---- config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
      hit_latency <= HIT_LATENCY_RST;
      miss_latency <= MISS_LATENCY_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
        CFG_HIT_LATENCY: hit_latency <= cfg_data[HIT_LAT_W-1:0];
        CFG_MISS_LATENCY: miss_latency <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- cell chain, newest tag enters at cell 0
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [TAG_BITS-1:0] prev_tag;
    if (i == 0) begin : g_head
      assign prev_tag = req_tag;
    end else begin : g_body
      assign prev_tag = cell_tag[i-1];
    end

    facl_cell #(
      .IDX      (i),
      .TAG_BITS (TAG_BITS),
      .OCC_W    (OCC_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .occupancy (occupancy),
      .req_tag   (req_tag),
      .prev_tag  (prev_tag),
      .tag       (cell_tag[i]),
      .match     (cell_match[i]),
      .last_tag  (cell_last[i])
    );
  end

  assign any_hit = |cell_match;

  // oldest live tag: only the cell at the end of the run drives its tag
  always_comb begin
    evict_tag = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      evict_tag = evict_tag | cell_last[i];
    end
  end

  // capacity zero acts as one, above the store size acts as the store size
  assign cap_eff = (capacity == '0) ? CW'(1) : CW'(capacity);
  assign full = (CW'(occupancy) >= cap_eff) || (occupancy == OCC_W'(ENTRIES));

  // ---- sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: state_next = ST_RES;
      ST_RES: begin
        if (res_go) begin
          state_next = in_accept ? ST_CMP : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_tag <= tag_in_ext[TAG_BITS-1:0];
    end
  end

  // ---- occupancy and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      hit_counter <= '0;
      memory_counter <= '0;
    end else if (res_go) begin
      if (any_hit) begin
        if (hit_counter != '1) begin
          hit_counter <= hit_counter + 1'b1;
        end
      end else begin
        if (memory_counter != '1) begin
          memory_counter <= memory_counter + 1'b1;
        end
        // a miss into a full store evicts one and appends one
        if (!full) begin
          occupancy <= occupancy + 1'b1;
        end
      end
    end
  end

  // counters only move on resolve, which waits for the result to drain
  assign hit_total = hit_counter;
  assign memory_total = memory_counter;

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_go) begin
      hit <= any_hit;
      latency <= any_hit ? LAT_W'(hit_latency) : miss_latency;
      evict_valid <= !any_hit && full;
      evicted_tag <= (!any_hit && full) ? evict_ext[IN_TAG_W-1:0] : '0;
    end
  end

`ifndef NO_ASSERTIONS
  // the fill level never runs past the number of cells
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(ENTRIES))
    else $error("occupancy beyond store size");

  // a compare cycle is always followed by a resolve cycle
  a_cmp_then_res: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |=> state == ST_RES)
    else $error("compare not followed by resolve");

  // an eviction only ever comes with a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && evict_valid |-> !hit)
    else $error("eviction reported on a hit");

  // the chain never shifts while a compare is under way
  a_no_shift_cmp: assert property (@(posedge clk) disable iff (rst)
    !(ctl.shift && ctl.compare))
    else $error("shift during compare");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/facl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// facl_cell
// one tag slot of the shift chain: holds a tag, compares, passes it on
// ----------------------------------------------------------------------------
module facl_cell
  import facl_pkg::*;
#(
  parameter int IDX = 0,
  parameter int TAG_BITS = 32,
  parameter int OCC_W = 6
) (
  input  wire                 clk,
  input  wire                 rst,
  input  facl_ctl_t           ctl,
  input  wire [OCC_W-1:0]     occupancy,
  input  wire [TAG_BITS-1:0]  req_tag,
  input  wire [TAG_BITS-1:0]  prev_tag,
  output logic [TAG_BITS-1:0] tag,
  output logic                match,
  output logic [TAG_BITS-1:0] last_tag
);

  logic valid;
  logic is_last;

  // slot holds a live tag while it lies within the occupancy
  assign valid = occupancy > OCC_W'(IDX);
  assign is_last = occupancy == OCC_W'(IDX + 1);
  assign last_tag = is_last ? tag : '0;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      tag <= prev_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.compare) begin
      match <= valid && (tag == req_tag);
    end
  end

endmodule
`default_nettype wire

>>> dv/tb_fifo_assoc_cache_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_assoc_cache_lookup_unit
// self-checking bench for the fifo associative cache lookup unit: a shadow
// tag store predicts hit, latency, eviction and both counters for every
// request word, and each result word is checked against the oldest prediction
// under bursty requests, patterned result stalls and several register settings
// ----------------------------------------------------------------------------
module tb_fifo_assoc_cache_lookup_unit;
  import facl_pkg::*;

  localparam int ENTRIES = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_PHASES = 12;
  localparam int WORDS_PER_PHASE = 160;

  // expected content of one result word
  typedef struct packed {
    logic                 hit;
    logic [LAT_W-1:0]     latency;
    logic                 evict_valid;
    logic [IN_TAG_W-1:0]  evicted_tag;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     memory_total;
  } lookup_res_t;

  // dut connections, all inputs known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [IN_TAG_W-1:0]   block_tag = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  hit;
  logic [LAT_W-1:0]      latency;
  logic                  evict_valid;
  logic [IN_TAG_W-1:0]   evicted_tag;
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      memory_total;

  fifo_assoc_cache_lookup_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .block_tag    (block_tag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .latency      (latency),
    .evict_valid  (evict_valid),
    .evicted_tag  (evicted_tag),
    .hit_total    (hit_total),
    .memory_total (memory_total)
  );

  always #6 clk = ~clk;

  // shadow copy of the cache: circular fifo of tags plus counters and registers
  logic [IN_TAG_W-1:0]  shadow_tags [ENTRIES];
  int                   shadow_head;
  int                   shadow_occ;
  logic [CNT_W-1:0]     shadow_hits;
  logic [CNT_W-1:0]     shadow_fetches;
  logic [CAP_W-1:0]     shadow_cap;
  logic [HIT_LAT_W-1:0] shadow_hit_lat;
  logic [LAT_W-1:0]     shadow_miss_lat;

  // request words waiting for the driver, and predicted result words
  logic [IN_TAG_W-1:0]  tag_pending_q [$];
  lookup_res_t          lookup_expect_q [$];

  int mismatches = 0;
  int idle_cycles = 0;
  logic in_took = 1'b0;   // request word accepted at the last rising edge

  // capacity zero acts as one, anything above the store size as the store size
  function automatic int usable_capacity(input logic [CAP_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > ENTRIES) return ENTRIES;
    return int'(cap);
  endfunction

  // one lookup against the shadow store; updates the shadow state
  function automatic lookup_res_t cache_lookup(input logic [IN_TAG_W-1:0] tag);
    lookup_res_t r;
    logic found;
    int i;
    r = '0;
    found = 1'b0;
    // only the occupied run is compared
    for (i = 0; i < shadow_occ; i++) begin
      if (shadow_tags[(shadow_head + i) % ENTRIES] == tag) found = 1'b1;
    end
    if (found) begin
      if (shadow_hits != '1) shadow_hits = shadow_hits + 1'b1;
      r.latency = LAT_W'(shadow_hit_lat);
    end else begin
      if (shadow_fetches != '1) shadow_fetches = shadow_fetches + 1'b1;
      r.latency = shadow_miss_lat;
      // full (or capacity lowered under occupancy): drop the oldest first
      if (shadow_occ >= usable_capacity(shadow_cap)) begin
        r.evict_valid = 1'b1;
        r.evicted_tag = shadow_tags[shadow_head];
        shadow_head = (shadow_head + 1) % ENTRIES;
        shadow_occ--;
      end
      if (shadow_occ < ENTRIES) begin
        shadow_tags[(shadow_head + shadow_occ) % ENTRIES] = tag;
        shadow_occ++;
      end
    end
    r.hit = found;
    r.hit_total = shadow_hits;
    r.memory_total = shadow_fetches;
    return r;
  endfunction

  // append one request word to the driver queue
  task automatic queue_tag(input logic [IN_TAG_W-1:0] t);
    tag_pending_q = {tag_pending_q, t};
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // wait until no request is left and every result word has come back
  task automatic drain_results();
    while (tag_pending_q.size() != 0 || in_valid || lookup_expect_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_CAPACITY:     shadow_cap = val[CAP_W-1:0];
      CFG_HIT_LATENCY:  shadow_hit_lat = val[HIT_LAT_W-1:0];
      CFG_MISS_LATENCY: shadow_miss_lat = val[LAT_W-1:0];
      default: ;
    endcase
  endtask

  // registers change only with the block idle
  task automatic apply_config(input logic [CFG_DATA_W-1:0] cap_raw,
                              input logic [CFG_DATA_W-1:0] hit_raw,
                              input logic [CFG_DATA_W-1:0] miss_raw);
    drain_results();
    write_reg(CFG_CAPACITY, cap_raw);
    write_reg(CFG_HIT_LATENCY, hit_raw);
    write_reg(CFG_MISS_LATENCY, miss_raw);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // driver: bursts of request words with random gaps, a word holds until taken
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // stalled word stays put
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (tag_pending_q.size() > 0) begin
      in_valid <= 1'b1;
      block_tag <= tag_pending_q.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        // half the bursts run back to back with no gap
        gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: stall mode picked for a random stretch of cycles
  int stall_mode = 0;
  int stall_left = 0;
  logic [2:0] stall_tick = '0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;                          // free flowing
        1: out_stall <= ($urandom_range(0, 3) == 0);   // light
        2: out_stall <= ($urandom_range(0, 3) != 0);   // heavy
        default: out_stall <= (stall_tick < 3'd3);     // periodic
      endcase
    end
  end

  // monitor: check result words first, then predict for the request word
  always @(posedge clk) begin : monitor
    lookup_res_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (lookup_expect_q.size() == 0) begin
          $display("%0t ns: result word with nothing expected, hit %b evict %b",
                   $time, hit, evict_valid);
          mismatches++;
        end else begin
          want = lookup_expect_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("latency", 32'(want.latency), 32'(latency));
          check_field("evict_valid", 32'(want.evict_valid), 32'(evict_valid));
          check_field("evicted_tag", want.evicted_tag, evicted_tag);
          check_field("hit_total", want.hit_total, hit_total);
          check_field("memory_total", want.memory_total, memory_total);
        end
      end
      if (in_valid && !in_stall)
        lookup_expect_q = {lookup_expect_q, cache_lookup(block_tag)};
    end
  end

  // watchdog on cycles with no traffic on any port
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no traffic for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_fifo_assoc_cache_lookup_unit NOT OK");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int phase;
    int k;
    int n_pool;
    int eff;
    logic [CAP_W-1:0] cap6;
    logic [CFG_DATA_W-1:0] cap_raw;
    logic [CFG_DATA_W-1:0] hit_raw;
    logic [CFG_DATA_W-1:0] miss_raw;
    logic [IN_TAG_W-1:0] pool [$];

    shadow_head = 0;
    shadow_occ = 0;
    shadow_hits = '0;
    shadow_fetches = '0;
    shadow_cap = CAPACITY_RST;
    shadow_hit_lat = HIT_LATENCY_RST;
    shadow_miss_lat = MISS_LATENCY_RST;
    for (k = 0; k < ENTRIES; k++) shadow_tags[k] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers: extreme tags, repeats that hit, walking patterns
    queue_tag(32'h0000_0000);
    queue_tag(32'hFFFF_FFFF);
    queue_tag(32'h0000_0000);
    queue_tag(32'hFFFF_FFFF);
    queue_tag(32'h0000_0001);
    queue_tag(32'h8000_0000);
    queue_tag(32'h5555_5555);
    queue_tag(32'hAAAA_AAAA);
    queue_tag(32'h0000_0001);
    queue_tag(32'hAAAA_AAAA);

    // capacity dropped under occupancy: every miss evicts, occupancy holds
    apply_config(10'd2, 10'd0, 10'd1023);
    queue_tag(32'h1234_5678);
    queue_tag(32'h0000_0000);
    queue_tag(32'h1234_5678);
    queue_tag(32'h8000_0000);

    // capacity zero behaves as one
    apply_config(10'd0, 10'd255, 10'd0);
    queue_tag(32'hDEAD_BEEF);
    queue_tag(32'hDEAD_BEEF);
    queue_tag(32'hCAFE_F00D);
    queue_tag(32'hDEAD_BEEF);

    // capacity above the store size saturates, upper data bits ignored
    apply_config(10'h3FF, 10'h3FF, 10'd1);
    queue_tag(32'h0000_0000);
    queue_tag(32'hFFFF_FFFF);
    queue_tag(32'h0000_0000);

    // random phases, each with a small tag pool so hits and evictions mix
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin cap_raw = 10'd1;  hit_raw = 10'd255; miss_raw = 10'd1023; end
        1: begin cap_raw = 10'd32; hit_raw = 10'd0;   miss_raw = 10'd0;    end
        2: begin cap_raw = 10'd40; hit_raw = 10'd17;  miss_raw = 10'd513;  end
        default: begin
          k = $urandom_range(0, 9);
          if (k < 6) cap6 = CAP_W'($urandom_range(1, 12));
          else if (k < 8) cap6 = CAP_W'($urandom_range(13, 32));
          else cap6 = CAP_W'($urandom_range(0, 63));
          cap_raw = {4'($urandom_range(0, 15)), cap6};
          hit_raw = CFG_DATA_W'($urandom_range(0, 1023));
          miss_raw = CFG_DATA_W'($urandom_range(0, 1023));
        end
      endcase
      apply_config(cap_raw, hit_raw, miss_raw);
      eff = usable_capacity(cap_raw[CAP_W-1:0]);
      pool.delete();
      n_pool = $urandom_range(1, eff + 4);
      for (k = 0; k < n_pool; k++) begin
        case ($urandom_range(0, 7))
          0: pool = {pool, 32'h1 << $urandom_range(0, 31)};
          1: pool = {pool, ~(32'h1 << $urandom_range(0, 31))};
          default: pool = {pool, 32'($urandom)};
        endcase
      end
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        if ($urandom_range(0, 3) != 0)
          queue_tag(pool[$urandom_range(0, n_pool - 1)]);
        else
          queue_tag($urandom);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("tb_fifo_assoc_cache_lookup_unit OK");
    else
      $display("tb_fifo_assoc_cache_lookup_unit NOT OK");
    $finish;
  end

endmodule
